// ----- hw/rtl/sll_pkg.sv -----
// shared types and codes for the sorted list insert/remove block
package sll_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;

    typedef logic [1:0] t_status;

    localparam t_status ST_INSERTED  = 2'd0;
    localparam t_status ST_REMOVED   = 2'd1;
    localparam t_status ST_NOT_FOUND = 2'd2;
    localparam t_status ST_FULL      = 2'd3;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // finished result handed from the engine to the output register
    typedef struct packed {
        logic               valid;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_result;

endpackage

// ----- hw/rtl/sll_if.sv -----
// request and result channel interfaces
interface sll_req_if
    import sll_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface sll_res_if
    import sll_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;

    modport source (output valid, output status, output count, input ready);
    modport sink   (input valid, input status, input count, output ready);
endinterface

// ----- hw/rtl/sorted_list_insert_remove.sv -----
// top level: sorted list of signed values with insert and remove requests
//
// Keeps up to CAPACITY signed 32-bit values in ascending order in a single
// synchronous RAM. An insert walks down from the last entry, moving each
// entry that is greater than or equal to the new value up one place, then
// writes the value. An insert into an empty store writes it without a walk.
// A remove walks up from the first entry, moving every entry after the first
// match down one place. It always reads every stored entry, whether or not
// a match is found. Refused requests (insert into a full store, remove from
// an empty one) skip the walk. The one read port of the RAM sets the pace:
// one entry per cycle. Each request gives exactly one result item with a
// status and the entry count after the request. The result sits in an output
// register, so the next request is taken while the previous result waits.
// A finished request stalls in the engine only while that register still
// holds an earlier result that the receiver has not taken. Stored values
// need no clearing after reset.
module sorted_list_insert_remove
    import sll_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sll_req_if.sink    i_req,
    sll_res_if.source  o_res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic               eng_idle;
    logic               res_free;
    t_result            eng_done;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [COUNT_W-1:0] r_out_count;

    assign i_req.ready = eng_idle;
    assign res_free    = !r_out_valid || o_res.ready;

    sll_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    sll_engine #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_req.valid && eng_idle),
        .i_kind     (i_req.req_type),
        .i_value    (i_req.value),
        .o_idle     (eng_idle),
        .i_res_free (res_free),
        .o_done     (eng_done),
        .o_we       (mem_we),
        .o_waddr    (mem_waddr),
        .o_wdata    (mem_wdata),
        .o_raddr    (mem_raddr),
        .i_rdata    (mem_rdata)
    );

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_done.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (eng_done.valid) begin
            r_out_status <= eng_done.status;
            r_out_count  <= eng_done.count;
        end
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.status = r_out_status;
    assign o_res.count  = r_out_count;

endmodule

// ----- hw/rtl/sll_mem.sv -----
// entry store: one write port, one read port with registered read data
module sll_mem
    import sll_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic [VALUE_W-1:0] i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output logic [VALUE_W-1:0] o_rdata
);

    logic [VALUE_W-1:0] r_mem [DEPTH];
    logic [VALUE_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port with registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/sll_engine.sv -----
// sequencer that walks the entry store to insert or remove one value
module sll_engine
    import sll_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int AW       = 6,
    parameter int CW       = 7
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_kind,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_idle,
    input  logic                      i_res_free,
    output t_result                   o_done,
    output logic                      o_we,
    output logic [AW-1:0]             o_waddr,
    output logic [VALUE_W-1:0]        o_wdata,
    output logic [AW-1:0]             o_raddr,
    input  logic [VALUE_W-1:0]        i_rdata
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_INS  = 5'b00010,
        S_REM  = 5'b00100,
        S_PUT  = 5'b01000,
        S_RESP = 5'b10000
    } t_state;

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    logic [AW-1:0]             r_pidx, n_pidx;
    logic [AW-1:0]             r_waddr, n_waddr;
    logic                      r_found, n_found;
    t_status                   r_status, n_status;
    logic signed [VALUE_W-1:0] r_val, n_val;

    logic          rd_ge;
    logic          rd_hit;
    logic [AW-1:0] last_idx;

    assign rd_ge    = $signed(i_rdata) >= r_val;
    assign rd_hit   = i_rdata == r_val;
    assign last_idx = AW'(r_count - 1'b1);

    // next-state logic
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_pidx   = r_pidx;
        n_waddr  = r_waddr;
        n_found  = r_found;
        n_status = r_status;
        n_val    = r_val;
        o_we     = 1'b0;
        o_waddr  = r_waddr;
        o_wdata  = r_val;
        o_raddr  = r_pidx;
        o_done   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_val = i_value;
                    if (i_kind == REQ_INSERT) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_RESP;
                        end else if (r_count == '0) begin
                            n_waddr = '0;
                            n_state = S_PUT;
                        end else begin
                            // walk down from the last entry
                            o_raddr = last_idx;
                            n_pidx  = last_idx;
                            n_state = S_INS;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_NOT_FOUND;
                            n_state  = S_RESP;
                        end else begin
                            // walk up from the first entry
                            o_raddr = '0;
                            n_pidx  = '0;
                            n_found = 1'b0;
                            n_state = S_REM;
                        end
                    end
                end
            end
            S_INS: begin
                if (rd_ge) begin
                    // shift this entry up one place
                    o_we    = 1'b1;
                    o_waddr = AW'(r_pidx + 1'b1);
                    o_wdata = i_rdata;
                    if (r_pidx == '0) begin
                        n_waddr = '0;
                        n_state = S_PUT;
                    end else begin
                        o_raddr = AW'(r_pidx - 1'b1);
                        n_pidx  = AW'(r_pidx - 1'b1);
                    end
                end else begin
                    n_waddr = AW'(r_pidx + 1'b1);
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                o_we     = 1'b1;
                o_waddr  = r_waddr;
                o_wdata  = r_val;
                n_count  = CW'(r_count + 1'b1);
                n_status = ST_INSERTED;
                n_state  = S_RESP;
            end
            S_REM: begin
                // once the match is passed, every later entry moves down
                if (r_found) begin
                    o_we    = 1'b1;
                    o_waddr = AW'(r_pidx - 1'b1);
                    o_wdata = i_rdata;
                end
                n_found = r_found | rd_hit;
                if (r_pidx == last_idx) begin
                    if (n_found) begin
                        n_count  = CW'(r_count - 1'b1);
                        n_status = ST_REMOVED;
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                    n_state = S_RESP;
                end else begin
                    o_raddr = AW'(r_pidx + 1'b1);
                    n_pidx  = AW'(r_pidx + 1'b1);
                end
            end
            S_RESP: begin
                if (i_res_free) begin
                    o_done.valid  = 1'b1;
                    o_done.status = r_status;
                    o_done.count  = COUNT_W'(r_count);
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_idle = r_state == S_IDLE;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // walk pointers and request payload
    always_ff @(posedge i_clk) begin
        r_pidx   <= n_pidx;
        r_waddr  <= n_waddr;
        r_found  <= n_found;
        r_status <= n_status;
        r_val    <= n_val;
    end

endmodule

// ----- sim/testbench.sv -----
// self-checking testbench for the sorted list insert/remove block
module testbench;
    import sll_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int HOLD_CYCLES  = 240;
    localparam int DRAIN_CYCLES = 100;
    localparam int REPORT_LIMIT = 10;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'h7fff_ffff;

    typedef struct {
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;

    sll_req_if req_ch ();
    sll_res_if res_ch ();

    sorted_list_insert_remove #(
        .CAPACITY (CAPACITY)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    // shadow copy of the list and the results still owed by the block
    logic signed [VALUE_W-1:0] sorted_values[$];
    t_outcome                  owed_results[$];

    int  fail_count    = 0;
    int  checked_count = 0;
    int  status_seen[4] = '{0, 0, 0, 0};
    int  peak_fill     = 0;
    bit  steady_flow   = 1'b0;
    int  hold_requests = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop if the block hangs
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // apply one request to the shadow list and return what the block must report
    function automatic t_outcome apply_request(input logic kind,
                                               input logic signed [VALUE_W-1:0] val);
        t_outcome res;
        int       pos;
        pos = sorted_values.size();
        if (kind == REQ_INSERT) begin
            if (sorted_values.size() >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                // new value goes ahead of any equal entries
                for (int i = 0; i < sorted_values.size(); i++) begin
                    if (sorted_values[i] >= val) begin
                        pos = i;
                        break;
                    end
                end
                sorted_values.insert(pos, val);
                res.status = ST_INSERTED;
            end
        end else begin
            res.status = ST_NOT_FOUND;
            for (int i = 0; i < sorted_values.size(); i++) begin
                if (sorted_values[i] == val) begin
                    sorted_values.delete(i);
                    res.status = ST_REMOVED;
                    break;
                end
            end
        end
        res.count = COUNT_W'(sorted_values.size());
        return res;
    endfunction

    // value mix: small range for duplicates, edge values, and full random
    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] v;
        int                        sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            v = $urandom_range(0, 15);
            v = v - 8;
        end else if (sel < 55) begin
            case ($urandom_range(0, 5))
                0: v = VAL_MIN;
                1: v = VAL_MAX;
                2: v = VAL_MIN + 1;
                3: v = VAL_MAX - 1;
                4: v = '0;
                default: v = '1;
            endcase
        end else begin
            v = $urandom;
        end
        return v;
    endfunction

    // removal target: mostly a value that is stored, else anything
    function automatic logic signed [VALUE_W-1:0] pick_remove_value();
        if (sorted_values.size() != 0 && $urandom_range(0, 99) < 70)
            return sorted_values[$urandom_range(0, sorted_values.size() - 1)];
        return pick_value();
    endfunction

    // offer one item and wait until the block takes it
    task automatic send_request(input logic kind, input logic signed [VALUE_W-1:0] val);
        t_outcome res;
        while (!steady_flow && $urandom_range(0, 99) < 13) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.value    <= val;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        res = apply_request(kind, val);
        owed_results.push_back(res);
        status_seen[res.status]++;
        if (sorted_values.size() > peak_fill) peak_fill = sorted_values.size();
    endtask

    // pause the sender until every owed result has come back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (owed_results.size() != 0) @(posedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_outcome exp_res;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            checked_count++;
            if (owed_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected result item: status %0d count %0d",
                             res_ch.status, res_ch.count);
            end else begin
                exp_res = owed_results.pop_front();
                if (res_ch.status !== exp_res.status) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("result %0d status: expected %0d, got %0d",
                                 checked_count, exp_res.status, res_ch.status);
                end
                if (res_ch.count !== exp_res.count) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("result %0d count: expected %0d, got %0d",
                                 checked_count, exp_res.count, res_ch.count);
                end
            end
        end
    end

    // result receiver with random stalls and requested long hold-offs
    initial begin : receiver
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (steady_flow) begin
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= ($urandom_range(0, 99) >= 13);
            end
        end
    end

    // edge values, duplicates, head/middle/tail removal, empty store
    task automatic test_directed_edges();
        send_request(REQ_REMOVE, '0);
        send_request(REQ_INSERT, '0);
        send_request(REQ_INSERT, VAL_MAX);
        send_request(REQ_INSERT, VAL_MIN);
        send_request(REQ_INSERT, '1);
        send_request(REQ_INSERT, 32'sd1);
        send_request(REQ_INSERT, VAL_MAX);
        send_request(REQ_INSERT, VAL_MIN);
        send_request(REQ_INSERT, '0);
        send_request(REQ_REMOVE, 32'sd5);
        send_request(REQ_REMOVE, VAL_MIN);
        send_request(REQ_REMOVE, VAL_MAX);
        send_request(REQ_REMOVE, VAL_MAX);
        send_request(REQ_REMOVE, '0);
        send_request(REQ_REMOVE, '1);
        send_request(REQ_REMOVE, 32'sd1);
        send_request(REQ_REMOVE, '0);
        send_request(REQ_REMOVE, VAL_MIN);
        send_request(REQ_REMOVE, VAL_MIN);
        send_request(REQ_INSERT, 32'h5555_5555);
        send_request(REQ_INSERT, 32'haaaa_aaaa);
        send_request(REQ_REMOVE, 32'haaaa_aaaa);
        send_request(REQ_REMOVE, 32'h5555_5555);
        wait_drained();
    endtask

    // fill the store, hit it while full, then free and refill a slot
    task automatic test_full_store();
        while (sorted_values.size() < CAPACITY)
            send_request(REQ_INSERT, pick_value());
        send_request(REQ_INSERT, VAL_MIN);
        send_request(REQ_INSERT, VAL_MAX);
        send_request(REQ_INSERT, sorted_values[CAPACITY / 2]);
        send_request(REQ_REMOVE, sorted_values[CAPACITY - 1]);
        send_request(REQ_INSERT, VAL_MAX);
        send_request(REQ_INSERT, '0);
        send_request(REQ_REMOVE, sorted_values[0]);
        send_request(REQ_INSERT, VAL_MIN);
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_output_backpressure();
        hold_requests <= hold_requests + 1;
        for (int k = 0; k < 6; k++) begin
            if (k % 2 == 0) send_request(REQ_INSERT, pick_value());
            else send_request(REQ_REMOVE, pick_remove_value());
        end
        wait_drained();
    endtask

    // random inserts and removes, swinging between empty and full
    task automatic test_random_traffic(input int n_items);
        int insert_pct;
        insert_pct = 75;
        for (int k = 0; k < n_items; k++) begin
            if (sorted_values.size() >= CAPACITY) insert_pct = 25;
            else if (sorted_values.size() == 0) insert_pct = 75;
            if ($urandom_range(0, 99) < insert_pct)
                send_request(REQ_INSERT, pick_value());
            else
                send_request(REQ_REMOVE, pick_remove_value());
        end
        wait_drained();
    endtask

    // same traffic with no idle cycles on either side
    task automatic test_steady_stream(input int n_items);
        steady_flow <= 1'b1;
        test_random_traffic(n_items);
        steady_flow <= 1'b0;
    endtask

    // main sequence
    initial begin
        i_rst_n         <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_INSERT;
        req_ch.value    <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();
        test_full_store();
        test_output_backpressure();
        test_random_traffic(250);
        test_steady_stream(120);
        test_output_backpressure();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("checked %0d results: %0d inserted, %0d removed, %0d not found, %0d refused",
                 checked_count, status_seen[ST_INSERTED], status_seen[ST_REMOVED],
                 status_seen[ST_NOT_FOUND], status_seen[ST_FULL]);
        $display("peak fill %0d of %0d entries, %0d errors", peak_fill, CAPACITY, fail_count);
        if (fail_count == 0 && owed_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/sll_pkg.sv
hw/rtl/sll_if.sv
hw/rtl/sll_mem.sv
hw/rtl/sll_engine.sv
hw/rtl/sorted_list_insert_remove.sv
sim/testbench.sv
